>>> hdl/three_key_longpress_repeat_combo_macros.svh
// ----------------------------------------------------------------------------
// three_key_longpress_repeat_combo_macros
// Assertion macros used by the checker file of the key controller.
// ----------------------------------------------------------------------------
`ifndef THREE_KEY_LONGPRESS_REPEAT_COMBO_MACROS_SVH
`define THREE_KEY_LONGPRESS_REPEAT_COMBO_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define KLRC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("key controller check failed");

// Check a property on every rising edge, reset included.
`define KLRC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("key controller reset check failed");

`endif

>>> hdl/klrc_pkg.sv
// ----------------------------------------------------------------------------
// klrc_pkg
// Types and constants of the three-key long-press and auto-repeat controller.
// ----------------------------------------------------------------------------
package klrc_pkg;

  localparam int TIMER_W = 32;
  localparam int NKEYS   = 3;

  // Key slots, in update order
  localparam logic [1:0] KEY_DOWN  = 2'd0;
  localparam logic [1:0] KEY_UP    = 2'd1;
  localparam logic [1:0] KEY_POWER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LONGPRESS = 2'd0;
  localparam logic [1:0] REG_REPEAT    = 2'd1;
  localparam logic [1:0] REG_RELEASE   = 2'd2;

  localparam logic [TIMER_W-1:0] LONGPRESS_RST = 32'd500000000;
  localparam logic [TIMER_W-1:0] REPEAT_RST    = 32'd200000000;
  localparam logic [TIMER_W-1:0] RELEASE_RST   = 32'd10000000;

  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_ENTER = 3'd2,
    EV_S     = 3'd3,
    EV_E     = 3'd4,
    EV_SPACE = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_PENDING  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_ADD  = 2'd1,
    SQ_EVAL = 2'd2,
    SQ_EMIT = 2'd3
  } seq_state_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [TIMER_W-1:0] value;
    logic               carry;
  } alu_res_t;

  typedef struct packed {
    logic [31:0] delta_ns;
    logic        vol_down_level;
    logic        vol_up_level;
    logic        power_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_event;
  } out_item_t;

endpackage

>>> hdl/klrc_alu.sv
// ----------------------------------------------------------------------------
// klrc_alu
// Shared 32-bit adder: saturating timer add, or subtract for a >= compare.
// ----------------------------------------------------------------------------
module klrc_alu (
  input  klrc_pkg::alu_op_t            op,
  input  logic [klrc_pkg::TIMER_W-1:0] a,
  input  logic [klrc_pkg::TIMER_W-1:0] b,
  output klrc_pkg::alu_res_t           res
);
  import klrc_pkg::*;

  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] b_eff;
  logic               sub;

  // Invert and carry in for subtract; carry out then means a >= b
  assign sub   = (op == ALU_SUB);
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{TIMER_W{1'b0}}, sub};

  // Saturate on add overflow
  assign res.value = (!sub && sum[TIMER_W]) ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
  assign res.carry = sum[TIMER_W];

endmodule

>>> hdl/three_key_longpress_repeat_combo.sv
// ----------------------------------------------------------------------------
// three_key_longpress_repeat_combo
// Long-press, auto-repeat and power-combo controller for three keys.
// ----------------------------------------------------------------------------
// A poll is taken when in_valid is high and in_stall low. The keys are then
// updated one after another (volume down, volume up, power), each in an add
// state and an eval state through one shared 32-bit adder: a saturating timer
// add, then a compare against the threshold that the key's level and repeat
// state select. The events of the poll are collected and delivered after the
// third key, one per cycle while out_stall is low, the final one marked with
// last_event. in_stall goes high once a poll is accepted and stays high until
// the last event is taken, or until the third key is done if none fired.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module three_key_longpress_repeat_combo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  klrc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output klrc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import klrc_pkg::*;

  seq_state_t         state, state_next;
  logic [TIMER_W-1:0] longpress_ns, repeat_ns, release_ns;
  phase_t             phase [NKEYS];
  logic [TIMER_W-1:0] timer [NKEYS];
  logic [NKEYS-1:0]   repeat_active;
  logic [NKEYS-1:0]   longpress_done;
  logic [NKEYS-1:0]   key_held;
  in_item_t           item;
  logic [1:0]         key;
  logic [TIMER_W-1:0] t_sum;
  event_t             ev_buf [NKEYS];
  logic [1:0]         ev_cnt;
  logic [1:0]         emit_idx;

  logic [NKEYS-1:0]   levels;
  logic               pressed;
  logic               in_accept;
  logic               emit_last;
  alu_op_t            alu_op;
  logic [TIMER_W-1:0] alu_a, alu_b;
  alu_res_t           alu_res;
  logic               ge;

  // Per-key update results
  logic               ev_fire;
  event_t             ev_code;
  phase_t             ph_new;
  logic [TIMER_W-1:0] tm_new;
  logic               rep_new, lpd_new;

  assign levels    = {item.power_level, item.vol_up_level, item.vol_down_level};
  assign pressed   = !levels[key];
  assign in_stall  = (state != SQ_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state == SQ_EMIT);
  assign emit_last = (emit_idx == ev_cnt - 2'd1);
  assign out_data.event_code = ev_buf[emit_idx];
  assign out_data.last_event = emit_last;

  // Feed the shared adder: timer add, then threshold compare
  always_comb begin
    if (state == SQ_ADD) begin
      alu_op = ALU_ADD;
      alu_a  = timer[key];
      alu_b  = item.delta_ns;
    end else begin
      alu_op = ALU_SUB;
      alu_a  = t_sum;
      if (!pressed) begin
        alu_b = release_ns;
      end else if (repeat_active[key]) begin
        alu_b = repeat_ns;
      end else begin
        alu_b = longpress_ns;
      end
    end
  end

  klrc_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign ge = alu_res.carry;

  // Work out the key's next state and event from the compare
  always_comb begin
    ev_fire = 1'b0;
    ev_code = event_t'({1'b0, key});
    ph_new  = phase[key];
    tm_new  = t_sum;
    rep_new = repeat_active[key];
    lpd_new = longpress_done[key];
    unique case (phase[key])
      PH_RELEASED: begin
        if (pressed) begin
          tm_new = '0;
          ph_new = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (pressed) begin
          if (repeat_active[key]) begin
            if (ge) begin
              ev_fire = 1'b1;
              tm_new  = '0;
            end
          end else if (!longpress_done[key] && ge) begin
            lpd_new = 1'b1;
            if (key == KEY_POWER) begin
              ev_fire = 1'b1;
              if (key_held[KEY_DOWN]) begin
                ev_code = EV_S;
              end else if (key_held[KEY_UP]) begin
                ev_code = EV_E;
              end else begin
                ev_code = EV_SPACE;
              end
            end else if (!key_held[KEY_POWER]) begin
              ev_fire = 1'b1;
              tm_new  = '0;
              rep_new = 1'b1;
            end
          end
        end else begin
          if (!longpress_done[key]) begin
            ev_fire = 1'b1;
            ph_new  = PH_PENDING;
          end else if (ge) begin
            tm_new  = '0;
            rep_new = 1'b0;
            lpd_new = 1'b0;
            ph_new  = PH_RELEASED;
          end
        end
      end
      default: begin
        tm_new  = '0;
        rep_new = 1'b0;
        lpd_new = 1'b0;
        ph_new  = PH_RELEASED;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        if (in_accept) begin
          state_next = SQ_ADD;
        end
      end
      SQ_ADD: begin
        state_next = SQ_EVAL;
      end
      SQ_EVAL: begin
        if (key != KEY_POWER) begin
          state_next = SQ_ADD;
        end else if (ev_fire || ev_cnt != 2'd0) begin
          state_next = SQ_EMIT;
        end else begin
          state_next = SQ_IDLE;
        end
      end
      SQ_EMIT: begin
        if (!out_stall && emit_last) begin
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold configuration registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      longpress_ns <= LONGPRESS_RST;
      repeat_ns    <= REPEAT_RST;
      release_ns   <= RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONGPRESS: longpress_ns <= cfg_data;
        REG_REPEAT:    repeat_ns    <= cfg_data;
        REG_RELEASE:   release_ns   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance key state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NKEYS; i++) begin
        phase[i] <= PH_RELEASED;
        timer[i] <= '0;
      end
      repeat_active  <= '0;
      longpress_done <= '0;
      key_held       <= '0;
    end else if (state == SQ_ADD) begin
      key_held[key] <= pressed;
    end else if (state == SQ_EVAL) begin
      phase[key]          <= ph_new;
      timer[key]          <= tm_new;
      repeat_active[key]  <= rep_new;
      longpress_done[key] <= lpd_new;
    end
  end

  // Sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      key      <= KEY_DOWN;
      ev_cnt   <= 2'd0;
      emit_idx <= 2'd0;
    end else begin
      unique case (state)
        SQ_IDLE: begin
          key      <= KEY_DOWN;
          ev_cnt   <= 2'd0;
          emit_idx <= 2'd0;
        end
        SQ_EVAL: begin
          if (ev_fire) begin
            ev_cnt <= ev_cnt + 2'd1;
          end
          if (key != KEY_POWER) begin
            key <= key + 2'd1;
          end
        end
        SQ_EMIT: begin
          if (!out_stall && !emit_last) begin
            emit_idx <= emit_idx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the poll, the timer sum and the events
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= in_data;
    end
    if (state == SQ_ADD) begin
      t_sum <= alu_res.value;
    end
    if (state == SQ_EVAL && ev_fire) begin
      ev_buf[ev_cnt] <= ev_code;
    end
  end

endmodule

>>> hdl/klrc_checker.sv
// ----------------------------------------------------------------------------
// klrc_checker
// Port-level checks of the key controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_key_longpress_repeat_combo_macros.svh"

module klrc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input klrc_pkg::out_item_t out_data
);
  import klrc_pkg::*;

  // No new poll while events of the previous one are on offer
  `KLRC_ASSERT(a_busy_while_emit, clk, rst, out_valid |-> in_stall)

  // An accepted poll keeps the input side closed for the next cycle
  `KLRC_ASSERT(a_stall_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall)

  // Nothing more is offered once the final event of a poll is taken
  `KLRC_ASSERT(a_last_ends_burst, clk, rst,
    (out_valid && !out_stall && out_data.last_event) |=> !out_valid)

  // A stalled transaction keeps its payload
  `KLRC_ASSERT(a_out_hold, clk, rst,
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

  // Reset leaves the block idle and ready
  `KLRC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (!out_valid && !in_stall))

endmodule

bind three_key_longpress_repeat_combo klrc_checker u_klrc_checker (.*);
